// ===== sv/pressure_sensor_compensation_defines.svh =====
// ----------------------------------------------------------------------------
// Pressure sensor compensation: assertion macros
// Shared helpers for the concurrent checks of the compensation block.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_SENSOR_COMPENSATION_DEFINES_SVH
`define PRESSURE_SENSOR_COMPENSATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// Pressure sensor compensation package
// Widths, scaling constants, microcode format and the microcode program.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psc_pkg;

    // Field widths of the ports.
    localparam int COEFF_W    = 16;
    localparam int WORD_W     = 24;
    localparam int PRES_W     = 22;
    localparam int TEMP_W     = 19;
    localparam int NUM_COEFFS = 6;
    localparam int CFG_IDX_W  = $clog2(NUM_COEFFS);

    // Internal datapath widths.
    localparam int DT_W       = WORD_W + 1;
    localparam int MA_W       = DT_W;
    localparam int SENS_W     = 35;
    localparam int OFF_W      = 35;
    localparam int SENS_SPLIT = 17;
    localparam int MB_W       = SENS_W - SENS_SPLIT;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int ACC_W      = 60;

    // Scaling of the first-order compensation.
    localparam int TEMP_BASE  = 2000;
    localparam int TEMP_SHIFT = 23;
    localparam int OFF_SHIFT  = 7;
    localparam int SENS_SHIFT = 8;
    localparam int P_SHIFT1   = 21;
    localparam int P_SHIFT2   = 15;
    localparam int OFF_SCALE  = 16;
    localparam int SENS_SCALE = 15;
    localparam int REF_SCALE  = 8;

    localparam logic [COEFF_W-1:0] COEFF_ALL_ONES = '1;

    // Calibration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS_COEFF,
        REG_OFFSET_COEFF,
        REG_SENS_TEMPCO,
        REG_OFFSET_TEMPCO,
        REG_REF_TEMPERATURE,
        REG_TEMP_SLOPE
    } t_reg_idx;

    // Multiplier operand selects.
    typedef enum logic {
        A_DT,
        A_WORD
    } t_a_sel;

    typedef enum logic [2:0] {
        B_C6,
        B_C4,
        B_C3,
        B_SENS_LO,
        B_SENS_HI
    } t_b_sel;

    // Register update performed by a step.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_DT,
        OP_TEMP,
        OP_OFF,
        OP_SENS,
        OP_ACC_LOAD,
        OP_ACC_ADD
    } t_alu_op;

    typedef enum logic {
        JMP_NONE,
        JMP_IF_TEMP_WORD
    } t_jump;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_TEMP_WORD,
        EMIT_PRESSURE
    } t_emit;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    // Step addresses of the program.
    localparam t_step STEP_DT      = 4'd0;
    localparam t_step STEP_MUL_C6  = 4'd1;
    localparam t_step STEP_TEMP    = 4'd2;
    localparam t_step STEP_OFF     = 4'd3;
    localparam t_step STEP_SENS    = 4'd4;
    localparam t_step STEP_MUL_LO  = 4'd5;
    localparam t_step STEP_MUL_HI  = 4'd6;
    localparam t_step STEP_ACC_ADD = 4'd7;
    localparam t_step STEP_EMIT_P  = 4'd8;
    localparam t_step STEP_STORE_T = 4'd9;

    // One control word.
    typedef struct packed {
        t_a_sel  a_sel;
        t_b_sel  b_sel;
        logic    mul_en;
        t_alu_op alu_op;
        t_jump   jump;
        t_step   target;
        t_emit   emit;
    } t_uword;

    // Sequencer to datapath.
    typedef struct packed {
        logic   accept;
        logic   exec;
        t_uword uw;
    } t_ctrl;

    // Datapath to sequencer.
    typedef struct packed {
        logic expect_pressure;
        logic out_blocked;
    } t_status;

    // Microcode program: first-order compensation of one raw word.
    function automatic t_uword ucode_rom(input t_step step);
        t_uword uw;
        uw = '{a_sel: A_DT, b_sel: B_C6, mul_en: 1'b0, alu_op: OP_NONE,
               jump: JMP_NONE, target: STEP_DT, emit: EMIT_NONE};
        case (step)
            STEP_DT: begin
                uw.alu_op = OP_DT;
                uw.jump   = JMP_IF_TEMP_WORD;
                uw.target = STEP_STORE_T;
            end
            STEP_MUL_C6: begin
                uw.mul_en = 1'b1;
                uw.b_sel  = B_C6;
            end
            STEP_TEMP: begin
                uw.alu_op = OP_TEMP;
                uw.mul_en = 1'b1;
                uw.b_sel  = B_C4;
            end
            STEP_OFF: begin
                uw.alu_op = OP_OFF;
                uw.mul_en = 1'b1;
                uw.b_sel  = B_C3;
            end
            STEP_SENS: begin
                uw.alu_op = OP_SENS;
            end
            STEP_MUL_LO: begin
                uw.mul_en = 1'b1;
                uw.a_sel  = A_WORD;
                uw.b_sel  = B_SENS_LO;
            end
            STEP_MUL_HI: begin
                uw.alu_op = OP_ACC_LOAD;
                uw.mul_en = 1'b1;
                uw.a_sel  = A_WORD;
                uw.b_sel  = B_SENS_HI;
            end
            STEP_ACC_ADD: begin
                uw.alu_op = OP_ACC_ADD;
            end
            STEP_EMIT_P: begin
                uw.emit = EMIT_PRESSURE;
            end
            STEP_STORE_T: begin
                uw.emit = EMIT_TEMP_WORD;
            end
            default: begin
                uw.emit = EMIT_TEMP_WORD;
            end
        endcase
        return uw;
    endfunction

endpackage

// ===== sv/psc_sequencer.sv =====
// ----------------------------------------------------------------------------
// Pressure sensor compensation: microcode sequencer
// Step counter over the program table, with the conditional jump on phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psc_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  psc_pkg::t_status i_status,
    output psc_pkg::t_ctrl   o_ctrl
);
    import psc_pkg::*;

    t_seq_state r_state, n_state;
    t_step      r_step, n_step;
    t_uword     w_uw;
    logic       w_accept;
    logic       w_exec;

    // State and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_step  <= STEP_DT;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Control word fetch, stepping and jumps.
    always_comb begin
        w_uw     = ucode_rom(r_step);
        w_accept = (r_state == SEQ_IDLE) && i_valid;
        // An emitting step waits while the output register is still held.
        w_exec   = (r_state == SEQ_RUN) &&
                   !((w_uw.emit != EMIT_NONE) && i_status.out_blocked);
        n_state  = r_state;
        n_step   = r_step;
        case (r_state)
            SEQ_IDLE: begin
                if (w_accept) begin
                    n_state = SEQ_RUN;
                    n_step  = STEP_DT;
                end
            end
            SEQ_RUN: begin
                if (w_exec) begin
                    if (w_uw.emit != EMIT_NONE) begin
                        n_state = SEQ_IDLE;
                    end else if ((w_uw.jump == JMP_IF_TEMP_WORD) &&
                                 !i_status.expect_pressure) begin
                        n_step = w_uw.target;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    assign o_stall       = (r_state != SEQ_IDLE);
    assign o_ctrl.accept = w_accept;
    assign o_ctrl.exec   = w_exec;
    assign o_ctrl.uw     = w_uw;

endmodule

// ===== sv/psc_datapath.sv =====
// ----------------------------------------------------------------------------
// Pressure sensor compensation: datapath
// Calibration registers, shared multiplier, working registers and the
// output register; all but the calibration registers follow the current control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psc_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  psc_pkg::t_ctrl                      i_ctrl,
    output psc_pkg::t_status                    o_status,
    input  logic [psc_pkg::WORD_W-1:0]          i_adc_word,
    input  logic                                i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [psc_pkg::COEFF_W-1:0]         i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_result_valid,
    output logic signed [psc_pkg::PRES_W-1:0]   o_pressure_out,
    output logic signed [psc_pkg::TEMP_W-1:0]   o_temperature_out,
    output logic                                o_next_conversion,
    output logic                                o_calibration_ok
);
    import psc_pkg::*;

    logic [COEFF_W-1:0]       r_coeff [NUM_COEFFS];
    logic [WORD_W-1:0]        r_held;
    logic                     r_expect;
    logic [WORD_W-1:0]        r_word;
    logic signed [DT_W-1:0]   r_dt;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [TEMP_W-1:0] r_temp;
    logic signed [OFF_W-1:0]  r_off;
    logic signed [SENS_W-1:0] r_sens;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     r_out_valid;
    logic                     r_res_valid;
    logic signed [PRES_W-1:0] r_pres;
    logic signed [TEMP_W-1:0] r_temp_out;
    logic                     r_next;
    logic                     r_cal_ok;

    logic signed [MA_W-1:0]   w_mul_a;
    logic signed [MB_W-1:0]   w_mul_b;
    logic signed [PROD_W-1:0] w_temp_sum;
    logic signed [ACC_W-1:0]  w_diff;
    logic signed [ACC_W-1:0]  w_p_full;
    logic                     w_p_fits;
    logic signed [PRES_W-1:0] w_p_sat;
    logic                     w_cal_ok;
    logic                     w_out_load;
    t_uword                   w_uw;

    assign w_uw = i_ctrl.uw;

    // Calibration register writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEFFS; i++) begin
                r_coeff[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_index <= REG_TEMP_SLOPE)) begin
            r_coeff[i_cfg_index] <= i_cfg_data;
        end
    end

    // Calibration is bad when any coefficient is zero or all ones.
    always_comb begin
        w_cal_ok = 1'b1;
        for (int i = 0; i < NUM_COEFFS; i++) begin
            if ((r_coeff[i] == '0) || (r_coeff[i] == COEFF_ALL_ONES)) begin
                w_cal_ok = 1'b0;
            end
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = (w_uw.a_sel == A_WORD) ? signed'({1'b0, r_word}) : r_dt;
        case (w_uw.b_sel)
            B_C6:      w_mul_b = signed'({{(MB_W-COEFF_W){1'b0}}, r_coeff[REG_TEMP_SLOPE]});
            B_C4:      w_mul_b = signed'({{(MB_W-COEFF_W){1'b0}},
                                          r_coeff[REG_OFFSET_TEMPCO]});
            B_C3:      w_mul_b = signed'({{(MB_W-COEFF_W){1'b0}}, r_coeff[REG_SENS_TEMPCO]});
            B_SENS_LO: w_mul_b = signed'({1'b0, r_sens[SENS_SPLIT-1:0]});
            B_SENS_HI: w_mul_b = r_sens[SENS_W-1:SENS_SPLIT];
            default:   w_mul_b = '0;
        endcase
    end

    // Temperature sum; final pressure: scale, subtract offset, scale again and saturate.
    always_comb begin
        w_temp_sum = (r_prod >>> TEMP_SHIFT) + PROD_W'(TEMP_BASE);
        w_diff     = (r_acc >>> P_SHIFT1) - ACC_W'(r_off);
        w_p_full   = w_diff >>> P_SHIFT2;
        w_p_fits   = (&w_p_full[ACC_W-1:PRES_W-1]) | ~(|w_p_full[ACC_W-1:PRES_W-1]);
        if (w_p_fits) begin
            w_p_sat = w_p_full[PRES_W-1:0];
        end else if (w_p_full[ACC_W-1]) begin
            w_p_sat = {1'b1, {(PRES_W-1){1'b0}}};
        end else begin
            w_p_sat = {1'b0, {(PRES_W-1){1'b1}}};
        end
    end

    assign w_out_load = i_ctrl.exec && (w_uw.emit != EMIT_NONE);

    // Raw word capture and phase state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_expect <= 1'b0;
        end else begin
            if (i_ctrl.exec && (w_uw.emit == EMIT_TEMP_WORD)) begin
                r_held   <= r_word;
                r_expect <= 1'b1;
            end else if (i_ctrl.exec && (w_uw.emit == EMIT_PRESSURE)) begin
                r_expect <= 1'b0;
            end
        end
    end

    // Working registers of the compensation arithmetic.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_word <= i_adc_word;
        end
        if (i_ctrl.exec && w_uw.mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (i_ctrl.exec) begin
            case (w_uw.alu_op)
                OP_DT: begin
                    r_dt <= signed'({1'b0, r_held}) -
                            signed'({1'b0, r_coeff[REG_REF_TEMPERATURE], {REF_SCALE{1'b0}}});
                end
                OP_TEMP: begin
                    r_temp <= w_temp_sum[TEMP_W-1:0];
                end
                OP_OFF: begin
                    r_off <= signed'(OFF_W'({r_coeff[REG_OFFSET_COEFF], {OFF_SCALE{1'b0}}})) +
                             OFF_W'(r_prod >>> OFF_SHIFT);
                end
                OP_SENS: begin
                    r_sens <= signed'(SENS_W'({r_coeff[REG_SENS_COEFF], {SENS_SCALE{1'b0}}})) +
                              SENS_W'(r_prod >>> SENS_SHIFT);
                end
                OP_ACC_LOAD: begin
                    r_acc <= ACC_W'(r_prod);
                end
                OP_ACC_ADD: begin
                    r_acc <= r_acc + (ACC_W'(r_prod) <<< SENS_SPLIT);
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_cal_ok <= w_cal_ok;
            if (w_uw.emit == EMIT_PRESSURE) begin
                r_res_valid <= 1'b1;
                r_pres      <= w_p_sat;
                r_temp_out  <= r_temp;
                r_next      <= 1'b1;
            end else begin
                r_res_valid <= 1'b0;
                r_pres      <= '0;
                r_temp_out  <= '0;
                r_next      <= 1'b0;
            end
        end
    end

    assign o_status.expect_pressure = r_expect;
    assign o_status.out_blocked     = r_out_valid && i_stall;

    assign o_valid           = r_out_valid;
    assign o_result_valid    = r_res_valid;
    assign o_pressure_out    = r_pres;
    assign o_temperature_out = r_temp_out;
    assign o_next_conversion = r_next;
    assign o_calibration_ok  = r_cal_ok;

endmodule

// ===== sv/pressure_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// Pressure sensor compensation: top level
// First-order temperature and pressure compensation of raw sensor words.
// ----------------------------------------------------------------------------
// Usage:
// Raw 24-bit words enter on i_valid/o_stall, strictly alternating between a
// temperature word and a pressure word, temperature first. Every word gives
// one result request on o_valid/i_stall. A temperature word is stored and
// gives a result with o_result_valid low; a pressure word gives compensated
// pressure and temperature in hundredths with o_result_valid high.
// Each word runs through a microcode program on one shared 25 x 18 bit
// multiplier. A temperature word takes 2 program steps, a pressure word 9;
// the last step loads the result into the output register. The block
// takes one word at a time: a new word is accepted only once the last
// step of the previous word has run. The output register lets the next
// word be accepted while a result waits; while the receiver stalls, the
// emitting step of the next word waits too.
// Calibration is written through i_cfg_we/i_cfg_index/i_cfg_data while idle.
// Synchronous reset clears the calibration, the held temperature word and
// the phase, so a temperature word is expected first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pressure_sensor_compensation_defines.svh"

module pressure_sensor_compensation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [psc_pkg::WORD_W-1:0]          i_adc_word,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_result_valid,
    output logic signed [psc_pkg::PRES_W-1:0]   o_pressure_out,
    output logic signed [psc_pkg::TEMP_W-1:0]   o_temperature_out,
    output logic                                o_next_conversion,
    output logic                                o_calibration_ok,
    input  logic                                i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [psc_pkg::COEFF_W-1:0]         i_cfg_data
);
    import psc_pkg::*;

    t_ctrl   w_ctrl;
    t_status w_status;

    // Program sequencer.
    psc_sequencer u_sequencer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    // Arithmetic and output register.
    psc_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (w_ctrl),
        .o_status          (w_status),
        .i_adc_word        (i_adc_word),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_result_valid    (o_result_valid),
        .o_pressure_out    (o_pressure_out),
        .o_temperature_out (o_temperature_out),
        .o_next_conversion (o_next_conversion),
        .o_calibration_ok  (o_calibration_ok)
    );

    // An accepted request starts the program straight away.
    `PSC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "sequencer did not start on an accepted request")

    // A temperature word gives an all-zero result.
    `PSC_ASSERT_SAME(a_temp_word_zero, i_clk, i_rst_n, o_valid && !o_result_valid, (o_pressure_out == '0) && (o_temperature_out == '0) && !o_next_conversion, "temperature word result is not cleared")

    // Pressure is only ever emitted when a pressure word was expected.
    `PSC_ASSERT_SAME(a_pressure_in_phase, i_clk, i_rst_n, w_ctrl.exec && (w_ctrl.uw.emit == EMIT_PRESSURE), w_status.expect_pressure, "pressure emitted out of phase")

    // Every emitted result flips the phase.
    `PSC_ASSERT_NEXT(a_phase_flip, i_clk, i_rst_n, w_ctrl.exec && (w_ctrl.uw.emit != EMIT_NONE), w_status.expect_pressure != $past(w_status.expect_pressure), "phase did not flip on a result")

endmodule
